/* hdl/rgcl_pkg.sv */
// ----------------------------------------------------------------------------
// rgcl_pkg: shared types and constants for the grid cell locator
// Field widths, opcode and status codes, and the command and status bundles
// that pass between the controller and the per-axis datapaths.
// ----------------------------------------------------------------------------
package rgcl_pkg;

  // default sizing
  localparam int unsigned MAX_BOUNDS_DEF = 256;
  localparam int unsigned COORD_BITS_DEF = 32;

  // fixed request and result field widths
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned AXIS_W   = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned CELL_W   = 8;
  localparam int unsigned NUM_AXES = 3;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_START  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_LOCATE = 2'd2;

  // result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  // controller to axis datapath
  typedef struct packed {
    logic latch;        // capture request operands
    logic start;        // write origin as boundary 0
    logic zero_origin;  // write 0 as boundary 0 (append before start)
    logic append;       // write running sum as next boundary
    logic srch_init;    // begin lower-bound search
    logic srch_step;    // one probe of the search
    logic capture;      // load result register
    logic locate;       // result comes from the search, else zero
  } rgcl_cmd_t;

  // axis datapath to controller
  typedef struct packed {
    logic empty;        // no boundaries held
    logic full;         // table at capacity
    logic done;         // search range exhausted
  } rgcl_sts_t;

endpackage

/* hdl/rgcl_axis.sv */
// ----------------------------------------------------------------------------
// rgcl_axis: boundary table and search datapath for one axis
// Holds the boundary memory, its fill count and last boundary, the
// saturating prefix-sum adder, and a lower-bound search doing one probe
// per cycle through the memory read port.
// ----------------------------------------------------------------------------
module rgcl_axis #(
  parameter int unsigned MAX_BOUNDS = rgcl_pkg::MAX_BOUNDS_DEF,
  parameter int unsigned COORD_BITS = rgcl_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rgcl_pkg::rgcl_cmd_t                 cmd_i,
  input  logic signed [rgcl_pkg::VALUE_W-1:0] load_value_i,
  input  logic signed [rgcl_pkg::VALUE_W-1:0] point_i,
  output rgcl_pkg::rgcl_sts_t                 sts_o,
  output logic [rgcl_pkg::CELL_W-1:0]         cell_o
);
  import rgcl_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_BOUNDS);
  localparam int unsigned CW  = $clog2(MAX_BOUNDS + 1);
  localparam int unsigned PW  = (COORD_BITS > VALUE_W) ? COORD_BITS : VALUE_W;
  localparam int unsigned SW  = PW + 1;
  localparam int unsigned EW  = (CW > CELL_W) ? CW : CELL_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_BOUNDS);
  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // boundary storage
  logic signed [COORD_BITS-1:0] mem [MAX_BOUNDS];
  logic signed [COORD_BITS-1:0] rd_q;
  logic        [AW-1:0]         rd_addr;
  logic        [AW-1:0]         wr_addr;
  logic signed [COORD_BITS-1:0] wr_data;
  logic                         we;

  logic [CW-1:0]                count_q, count_d;
  logic [CW-1:0]                len_q, len_d;
  logic [CW-1:0]                first_q, first_d;
  logic signed [COORD_BITS-1:0] last_q;
  logic signed [VALUE_W-1:0]    load_q;
  logic signed [VALUE_W-1:0]    point_q;
  logic [CELL_W-1:0]            cell_q;

  logic signed [SW-1:0]         add_a, add_b, sum;
  logic [SW-COORD_BITS:0]       sum_hi;
  logic                         in_range;
  logic signed [PW-1:0]         rd_ext, pt_ext;
  logic                         probe_lt;
  logic [CW-1:0]                half, first_n, len_n;
  logic [CW-1:0]                pos_m1;
  logic [EW-1:0]                pos_ext;

  // saturating add: origin, zero, or last boundary plus cell size
  always_comb begin
    add_a    = cmd_i.append ? SW'(last_q) : '0;
    add_b    = cmd_i.zero_origin ? '0 : SW'(load_q);
    sum      = add_a + add_b;
    sum_hi   = sum[SW-1:COORD_BITS-1];
    in_range = (&sum_hi) || !(|sum_hi);
    if (in_range) begin
      wr_data = sum[COORD_BITS-1:0];
    end else if (sum[SW-1]) begin
      wr_data = C_MIN;
    end else begin
      wr_data = C_MAX;
    end
    we      = cmd_i.start || cmd_i.zero_origin || cmd_i.append;
    wr_addr = cmd_i.append ? count_q[AW-1:0] : '0;
  end

  // one lower-bound probe per cycle
  always_comb begin
    rd_ext   = PW'(rd_q);
    pt_ext   = PW'(point_q);
    probe_lt = rd_ext < pt_ext;
    half     = len_q >> 1;
    if (len_q == '0) begin
      first_n = first_q;
      len_n   = len_q;
    end else if (probe_lt) begin
      first_n = first_q + half + CW'(1);
      len_n   = len_q - half - CW'(1);
    end else begin
      first_n = first_q;
      len_n   = half;
    end
    if (cmd_i.srch_init) begin
      rd_addr = AW'(count_q >> 1);
    end else begin
      rd_addr = AW'(first_n + (len_n >> 1));
    end
  end

  // next count and search range
  always_comb begin
    count_d = count_q;
    len_d   = len_q;
    first_d = first_q;
    if (cmd_i.start || cmd_i.zero_origin) begin
      count_d = CW'(1);
    end else if (cmd_i.append) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.srch_init) begin
      first_d = '0;
      len_d   = count_q;
    end else if (cmd_i.srch_step) begin
      first_d = first_n;
      len_d   = len_n;
    end
  end

  // cell index: position minus one, clamped at zero, low bits kept
  always_comb begin
    pos_m1  = (first_q == '0) ? '0 : first_q - CW'(1);
    pos_ext = EW'(pos_m1);
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      len_q   <= '0;
    end else begin
      count_q <= count_d;
      len_q   <= len_d;
    end
  end

  // operands, running boundary, result
  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    if (cmd_i.latch) begin
      load_q  <= load_value_i;
      point_q <= point_i;
    end
    if (we) begin
      last_q <= wr_data;
    end
    if (cmd_i.capture) begin
      cell_q <= cmd_i.locate ? pos_ext[CELL_W-1:0] : '0;
    end
  end

  // boundary memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  assign sts_o.empty = (count_q == '0);
  assign sts_o.full  = (count_q == FULL_CNT);
  assign sts_o.done  = (len_q == '0);
  assign cell_o      = cell_q;

  // checks
  a_no_append_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.append |-> count_q < FULL_CNT)
    else $error("append issued to a full table");

  a_search_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.srch_step && len_q != '0) |=> len_q < $past(len_q))
    else $error("search range did not shrink");

  a_origin_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.start || cmd_i.zero_origin) |=> count_q == CW'(1))
    else $error("origin write did not leave one boundary");

endmodule

/* hdl/rgcl_ctrl.sv */
// ----------------------------------------------------------------------------
// rgcl_ctrl: sequencer for the grid cell locator
// Takes one request at a time, decodes it into axis datapath commands,
// runs the search of a locate until every axis is done and hands the
// result to the output register when it is free.
// ----------------------------------------------------------------------------
module rgcl_ctrl (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               in_valid_i,
  output logic                                               in_stall_o,
  input  logic [rgcl_pkg::OPCODE_W-1:0]                      opcode_i,
  input  logic [rgcl_pkg::AXIS_W-1:0]                        axis_i,
  output logic                                               out_valid_o,
  input  logic                                               out_stall_i,
  output logic                                               status_o,
  output rgcl_pkg::rgcl_cmd_t [rgcl_pkg::NUM_AXES-1:0]       cmd_o,
  input  rgcl_pkg::rgcl_sts_t [rgcl_pkg::NUM_AXES-1:0]       sts_i
);
  import rgcl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_APPEND,
    S_SEARCH,
    S_FINISH
  } state_e;

  state_e                state_q;
  logic [OPCODE_W-1:0]   op_q;
  logic [AXIS_W-1:0]     axis_q;
  logic                  drop_q;
  logic                  out_valid_q;
  logic                  status_q;

  logic                  accept;
  logic                  slot_free;
  logic                  all_done;
  logic [NUM_AXES-1:0]   sel;
  logic                  sel_full;
  logic                  sel_empty;
  logic                  axis_ok;

  // decode and command generation
  always_comb begin
    accept    = in_valid_i && (state_q == S_IDLE);
    slot_free = !out_valid_q || !out_stall_i;
    all_done  = 1'b1;
    sel_full  = 1'b0;
    sel_empty = 1'b0;
    for (int a = 0; a < NUM_AXES; a++) begin
      sel[a]    = (axis_q == AXIS_W'(a));
      all_done  = all_done && sts_i[a].done;
      sel_full  = sel_full || (sel[a] && sts_i[a].full);
      sel_empty = sel_empty || (sel[a] && sts_i[a].empty);
    end
    axis_ok = |sel;

    for (int a = 0; a < NUM_AXES; a++) begin
      cmd_o[a]        = '0;
      cmd_o[a].latch  = accept;
      cmd_o[a].locate = (op_q == OP_LOCATE);
      unique case (state_q)
        S_EXEC: begin
          if (op_q == OP_LOCATE) begin
            cmd_o[a].srch_init = 1'b1;
          end else if (op_q == OP_START) begin
            cmd_o[a].start = sel[a];
          end else if (op_q == OP_APPEND && !sel_full) begin
            cmd_o[a].zero_origin = sel[a] && sel_empty;
            cmd_o[a].append      = sel[a] && !sel_empty;
          end
        end
        S_APPEND: begin
          cmd_o[a].append = sel[a];
        end
        S_SEARCH: begin
          cmd_o[a].srch_step = !all_done;
        end
        S_FINISH: begin
          cmd_o[a].capture = slot_free;
        end
        default: begin
        end
      endcase
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_START;
      axis_q      <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= STATUS_OK;
    end else begin
      // result taken and no new one posted this cycle
      if (out_valid_q && !out_stall_i && state_q != S_FINISH) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q    <= opcode_i;
            axis_q  <= axis_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          drop_q <= (op_q == OP_APPEND) && axis_ok && sel_full;
          if (op_q == OP_LOCATE) begin
            state_q <= S_SEARCH;
          end else if (op_q == OP_APPEND && axis_ok && !sel_full && sel_empty) begin
            state_q <= S_APPEND;
          end else begin
            state_q <= S_FINISH;
          end
        end
        S_APPEND: begin
          state_q <= S_FINISH;
        end
        S_SEARCH: begin
          if (all_done) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            status_q    <= drop_q ? STATUS_DROPPED : STATUS_OK;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

  // checks
  a_search_is_locate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (op_q == OP_LOCATE))
    else $error("search running for a non-locate request");

  a_finish_posts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && slot_free) |=> out_valid_q)
    else $error("finished request did not post a result");

  a_accept_execs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_EXEC))
    else $error("accepted request not decoded");

endmodule

/* hdl/rectilinear_grid_cell_locator.sv */
// ----------------------------------------------------------------------------
// rectilinear_grid_cell_locator: per-axis boundary tables and point lookup
// Builds three prefix-sum boundary tables from start and append requests
// and answers locate requests with a lower-bound search on each axis.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------
//   in      | in_valid_i / in_stall_o  | opcode, axis, load_value, point_xyz
//   out     | out_valid_o / out_stall_i| cell_x, cell_y, cell_z, status
//
// A request occupies the block from acceptance until its result is
// registered: decode and finish for start and append, plus an append step
// for an append to an axis never started; decode, search and finish for
// locate, at most clog2(MAX_BOUNDS) + 1 probes (9 at 256 entries), one per
// cycle on the single read port of each axis memory, axes side by side.
// Reset empties all tables at once; there is no clearing pass. A stalled
// result holds the output register and the finished request waits there.
// ----------------------------------------------------------------------------
module rectilinear_grid_cell_locator #(
  parameter int unsigned MAX_BOUNDS = rgcl_pkg::MAX_BOUNDS_DEF,
  parameter int unsigned COORD_BITS = rgcl_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [rgcl_pkg::OPCODE_W-1:0]       opcode_i,
  input  logic [rgcl_pkg::AXIS_W-1:0]         axis_i,
  input  logic signed [rgcl_pkg::VALUE_W-1:0] load_value_i,
  input  logic signed [rgcl_pkg::VALUE_W-1:0] point_x_i,
  input  logic signed [rgcl_pkg::VALUE_W-1:0] point_y_i,
  input  logic signed [rgcl_pkg::VALUE_W-1:0] point_z_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [rgcl_pkg::CELL_W-1:0]         cell_x_o,
  output logic [rgcl_pkg::CELL_W-1:0]         cell_y_o,
  output logic [rgcl_pkg::CELL_W-1:0]         cell_z_o,
  output logic                                status_o
);
  import rgcl_pkg::*;

  rgcl_cmd_t [NUM_AXES-1:0] cmd;
  rgcl_sts_t [NUM_AXES-1:0] sts;

  // sequencer
  rgcl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .axis_i      (axis_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // x axis
  rgcl_axis #(
    .MAX_BOUNDS (MAX_BOUNDS),
    .COORD_BITS (COORD_BITS)
  ) u_axis_x (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd[0]),
    .load_value_i (load_value_i),
    .point_i      (point_x_i),
    .sts_o        (sts[0]),
    .cell_o       (cell_x_o)
  );

  // y axis
  rgcl_axis #(
    .MAX_BOUNDS (MAX_BOUNDS),
    .COORD_BITS (COORD_BITS)
  ) u_axis_y (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd[1]),
    .load_value_i (load_value_i),
    .point_i      (point_y_i),
    .sts_o        (sts[1]),
    .cell_o       (cell_y_o)
  );

  // z axis
  rgcl_axis #(
    .MAX_BOUNDS (MAX_BOUNDS),
    .COORD_BITS (COORD_BITS)
  ) u_axis_z (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd[2]),
    .load_value_i (load_value_i),
    .point_i      (point_z_i),
    .sts_o        (sts[2]),
    .cell_o       (cell_z_o)
  );

endmodule
